// ----- rtl/lps_pkg.sv -----
`default_nettype none

package lps_pkg;

   localparam int unsigned LIMIT_W       = 12;
   localparam int unsigned CNT_W         = LIMIT_W + 1;
   localparam int unsigned MAX_LIMIT_DEF = 4096;

   typedef struct packed {
      logic [LIMIT_W-1:0] prime;
      logic               found;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/lps_ram.sv -----
`default_nettype none

module lps_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/lps_ctrl.sv -----
`default_nettype none

module lps_ctrl import lps_pkg::*; #(
   parameter int unsigned MAX_LIMIT = MAX_LIMIT_DEF,
   localparam int unsigned AW       = $clog2(MAX_LIMIT)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [LIMIT_W-1:0] limit,
   input  wire logic               out_free,
   output logic                    busy,
   output logic                    res_valid,
   output result_type              res,
   output logic                    ram_we,
   output logic      [AW-1:0]      ram_addr,
   output logic      [0:0]         ram_wdata,
   input  wire logic [0:0]         ram_rdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FILL   = 3'd1;
   localparam logic [2:0] ST_SV_RD  = 3'd2;
   localparam logic [2:0] ST_SV_CK  = 3'd3;
   localparam logic [2:0] ST_STRIKE = 3'd4;
   localparam logic [2:0] ST_SC_RD  = 3'd5;
   localparam logic [2:0] ST_SC_CK  = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   localparam int unsigned NMAX_INT = (MAX_LIMIT - 1 > (1 << LIMIT_W) - 1) ?
                                      (1 << LIMIT_W) - 1 : MAX_LIMIT - 1;
   localparam logic [LIMIT_W-1:0] NMAX = LIMIT_W'(NMAX_INT);

   localparam logic [LIMIT_W-1:0] FIRST_PRIME = LIMIT_W'(2);

   logic [2:0]         state_ff, state_in;
   logic [LIMIT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [LIMIT_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0]   psq_ff, psq_in;
   logic [LIMIT_W-1:0] prime_ff, prime_in;
   logic               found_ff, found_in;

   logic [CNT_W-1:0]   n_ext;
   logic [CNT_W-1:0]   i_next;
   logic [CNT_W-1:0]   psq_next;

   assign n_ext    = {1'b0, n_ff};
   assign i_next   = i_ff + CNT_W'(p_ff);
   assign psq_next = psq_ff + CNT_W'({p_ff, 1'b1});

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      p_in      = p_ff;
      psq_in    = psq_ff;
      prime_in  = prime_ff;
      found_in  = found_ff;
      ram_we    = 1'b0;
      ram_addr  = AW'(p_ff);
      ram_wdata = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in     = (limit > NMAX) ? NMAX : limit;
               i_in     = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(i_ff);
            ram_wdata = 1'b1;
            i_in      = i_ff + CNT_W'(1);
            if (i_ff == n_ext) begin
               p_in     = FIRST_PRIME;
               psq_in   = CNT_W'(4);
               state_in = ST_SV_RD;
            end
         end
         ST_SV_RD: begin
            ram_addr = AW'(p_ff);
            if (psq_ff > n_ext) begin
               p_in = n_ff;
               if (n_ff < FIRST_PRIME) begin
                  prime_in = '0;
                  found_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SC_RD;
               end
            end else begin
               state_in = ST_SV_CK;
            end
         end
         ST_SV_CK: begin
            if (ram_rdata[0]) begin
               i_in     = psq_ff;
               state_in = ST_STRIKE;
            end else begin
               p_in     = p_ff + LIMIT_W'(1);
               psq_in   = psq_next;
               state_in = ST_SV_RD;
            end
         end
         ST_STRIKE: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(i_ff);
            ram_wdata = 1'b0;
            i_in      = i_next;
            if (i_next > n_ext) begin
               p_in     = p_ff + LIMIT_W'(1);
               psq_in   = psq_next;
               state_in = ST_SV_RD;
            end
         end
         ST_SC_RD: begin
            ram_addr = AW'(p_ff);
            state_in = ST_SC_CK;
         end
         ST_SC_CK: begin
            if (ram_rdata[0]) begin
               prime_in = p_ff;
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (p_ff == FIRST_PRIME) begin
               prime_in = '0;
               found_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               p_in     = p_ff - LIMIT_W'(1);
               state_in = ST_SC_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff     <= n_in;
      i_ff     <= i_in;
      p_ff     <= p_in;
      psq_ff   <= psq_in;
      prime_ff <= prime_in;
      found_ff <= found_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res.prime = prime_ff;
   assign res.found = found_ff;

   a_strike_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STRIKE) |-> (i_ff <= n_ext) && (i_ff >= psq_ff))
      else $error("strike address outside p*p..n");

   a_sieve_prime_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SV_CK) |-> (psq_ff <= n_ext) && (p_ff >= FIRST_PRIME))
      else $error("sieve probe beyond square root of limit");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SC_RD) |-> (p_ff <= n_ff) && (p_ff >= FIRST_PRIME))
      else $error("scan index outside 2..n");

endmodule

`default_nettype wire

// ----- rtl/largest_prime_sieve.sv -----
// Channel   | Direction | Ports                                    | Transaction
// req_      | in        | req_valid, req_stall, req_limit          | one limit n
// rsp_      | out       | rsp_valid, rsp_stall, rsp_largest_prime, | one result per limit
//           |           | rsp_found                                |
//
// Per transaction: accept, fill map entries 0..n, a read and a check per p with
// p*p <= n, end the sieve, a strike write per multiple of each prime p from p*p to n,
// a read and check per index down from n, then hand over, all through the single map port.
// One limit is worked at a time; req_stall is high from acceptance until the result
// leaves the engine for the output register.
// Reset is synchronous and clears control only; the map needs no clearing since each
// transaction fills entries 0..n before reading any of them.
// A held rsp_stall keeps the result in the output register and the engine waits in its
// final state; a new limit is taken while the previous result is still held.
`default_nettype none

module largest_prime_sieve import lps_pkg::*; #(
   parameter int unsigned MAX_LIMIT = MAX_LIMIT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [LIMIT_W-1:0] req_limit,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [LIMIT_W-1:0] rsp_largest_prime,
   output logic                    rsp_found
);

   localparam int unsigned AW = $clog2(MAX_LIMIT);

   logic               busy;
   logic               res_valid;
   result_type         res;
   logic               out_free;
   logic               start;
   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [0:0]         ram_wdata;
   logic [0:0]         ram_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0] rsp_prime_ff, rsp_prime_in;
   logic               rsp_found_ff, rsp_found_in;

   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   lps_ctrl #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .limit     (req_limit),
      .out_free  (out_free),
      .busy      (busy),
      .res_valid (res_valid),
      .res       (res),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   lps_ram #(
      .WIDTH (1),
      .DEPTH (MAX_LIMIT)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_found_in = rsp_found_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_prime_in = res.prime;
            rsp_found_in = res.found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_prime_ff <= rsp_prime_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_largest_prime = rsp_prime_ff;
   assign rsp_found         = rsp_found_ff;

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_largest_prime == '0))
      else $error("no prime found but result non-zero");

   a_found_at_least_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_largest_prime >= LIMIT_W'(2)))
      else $error("found result below two");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine not busy after taking a limit");

   a_handover_needs_room: assert property (@(posedge clock) disable iff (reset)
      (res_valid && rsp_valid && rsp_stall) |=> res_valid)
      else $error("result left engine while output register held");

endmodule

`default_nettype wire

// ----- dv/largest_prime_sieve_test.sv -----
`timescale 1ns / 1ps

module largest_prime_sieve_test import lps_pkg::*;;

   localparam int unsigned RANDOM_LIMITS = 80;
   localparam int unsigned QUIET_FROM    = 64;

   class prime_scoreboard;
      bit          sieve_map [MAX_LIMIT_DEF];
      result_type  expected_primes [$];
      int unsigned errors;

      function new();
         errors = 0;
      endfunction

      function result_type largest_prime_upto(logic [LIMIT_W-1:0] n);
         int unsigned top;
         int unsigned p;
         int unsigned i;
         result_type  r;
         top = n;
         if (top > MAX_LIMIT_DEF - 1) begin
            top = MAX_LIMIT_DEF - 1;
         end
         for (i = 0; i <= top; i++) begin
            sieve_map[i] = 1'b1;
         end
         for (p = 2; p * p <= top; p++) begin
            if (sieve_map[p]) begin
               for (i = p * p; i <= top; i += p) begin
                  sieve_map[i] = 1'b0;
               end
            end
         end
         r.prime = '0;
         r.found = 1'b0;
         for (p = top; p >= 2; p--) begin
            if (sieve_map[p]) begin
               r.prime = p[LIMIT_W-1:0];
               r.found = 1'b1;
               break;
            end
         end
         return r;
      endfunction

      function void note_limit(logic [LIMIT_W-1:0] n);
         expected_primes.push_back(largest_prime_upto(n));
      endfunction

      function void check_result(logic [LIMIT_W-1:0] prime, logic found);
         result_type exp_r;
         if (expected_primes.size() == 0) begin
            $error("result with no limit pending: largest_prime %0d found %0b", prime, found);
            errors++;
         end else begin
            exp_r = expected_primes.pop_front();
            if (prime !== exp_r.prime) begin
               $error("largest_prime: expected %0d, actual %0d", exp_r.prime, prime);
               errors++;
            end
            if (found !== exp_r.found) begin
               $error("found: expected %0b, actual %0b", exp_r.found, found);
               errors++;
            end
         end
      endfunction

      function int unsigned pending();
         return expected_primes.size();
      endfunction

      function void report_leftover();
         if (expected_primes.size() != 0) begin
            $error("%0d results never arrived", expected_primes.size());
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [LIMIT_W-1:0] req_limit;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [LIMIT_W-1:0] rsp_largest_prime;
   logic               rsp_found;
   bit                 quiet;

   prime_scoreboard sb;

   largest_prime_sieve dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_limit         (req_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_largest_prime (rsp_largest_prime),
      .rsp_found         (rsp_found)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("largest_prime_sieve_test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_largest_prime, rsp_found);
         end
         if (req_valid && !req_stall) begin
            sb.note_limit(req_limit);
         end
      end
   end

   // result-side back-pressure in bursts
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(1, 15);
         end else begin
            rsp_stall <= 1'b0;
            hold = $urandom_range(1, 20);
         end
         repeat (hold) @(negedge clock);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_limit(input logic [LIMIT_W-1:0] n);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_limit <= n;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // mostly small limits to keep the run short, a few near the top of the map
   function automatic logic [LIMIT_W-1:0] pick_limit();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         return LIMIT_W'($urandom_range(0, 3));
      end else if (r < 65) begin
         return LIMIT_W'($urandom_range(0, 255));
      end else if (r < 92) begin
         return LIMIT_W'($urandom_range(0, 4095));
      end else begin
         return LIMIT_W'($urandom_range(3800, 4095));
      end
   endfunction

   initial begin
      logic [LIMIT_W-1:0] directed_limits [$];
      int unsigned        k;
      sb        = new();
      quiet     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_limit = '0;
      directed_limits = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9,
                          12'd25, 12'd49, 12'd120, 12'd127, 12'd1024, 12'd2047,
                          12'd2048, 12'hAAA, 12'h555, 12'd4092, 12'd4093, 12'd4094,
                          12'd4095};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_limits[j]) begin
         send_limit(directed_limits[j]);
      end
      for (k = 0; k < RANDOM_LIMITS; k++) begin
         if (k == QUIET_FROM) begin
            quiet = 1'b1;
         end
         send_limit(pick_limit());
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      sb.report_leftover();
      if (sb.errors == 0) begin
         $display("largest_prime_sieve_test passed");
      end else begin
         $display("largest_prime_sieve_test failed");
      end
      $finish;
   end

endmodule
